[rtl/sha256_byte_stream_hasher_defines.svh]
// assertion macros shared by the sha-256 byte stream hasher rtl
// no dependencies; included by files that carry assertions
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// condition must hold in the same cycle
`define SHA256BSH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after
`define SHA256BSH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sha256bsh_pkg.sv]
// shared types and constants of the sha-256 byte stream hasher
// no dependencies
`default_nettype none

package sha256bsh_pkg;

   typedef logic [31:0] word32_type;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam word32_type HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word32_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic [7:0] byte_val;
      logic       step;
      logic       expand;
   } sched_ctrl_type;

   typedef struct packed {
      logic init;
      logic step;
      logic add;
      logic clear;
   } core_ctrl_type;

endpackage

`default_nettype wire

[rtl/sha256bsh_sched.sv]
// block buffer and message schedule: bytes shift in, then words rotate and expand
// depends on sha256bsh_pkg
`default_nettype none

module sha256bsh_sched (
   input  wire logic                         clock,
   input  wire sha256bsh_pkg::sched_ctrl_type ctrl,
   output sha256bsh_pkg::word32_type         w
);
   import sha256bsh_pkg::*;

   word32_type words_ff [16];
   word32_type words_in [16];
   word32_type w_calc;

   function automatic word32_type small_sig0(input word32_type x);
      small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word32_type small_sig1(input word32_type x);
      small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   // taps: word 0 is w[t-16], 1 is w[t-15], 9 is w[t-7], 14 is w[t-2]
   always_comb begin
      w_calc = words_ff[0] + small_sig0(words_ff[1]) + words_ff[9] + small_sig1(words_ff[14]);
      w = ctrl.expand ? w_calc : words_ff[0];
   end

   always_comb begin
      words_in = words_ff;
      if (ctrl.load) begin
         // whole buffer moves up by one byte, big-endian packing falls out
         for (int i = 0; i < 15; i++) begin
            words_in[i] = {words_ff[i][23:0], words_ff[i+1][31:24]};
         end
         words_in[15] = {words_ff[15][23:0], ctrl.byte_val};
      end else if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            words_in[i] = words_ff[i+1];
         end
         words_in[15] = w;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

`default_nettype wire

[rtl/sha256bsh_core.sv]
// compression round unit: working words, one shared round datapath, hash words
// depends on sha256bsh_pkg
`default_nettype none

module sha256bsh_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sha256bsh_pkg::core_ctrl_type ctrl,
   input  wire logic [5:0]                  round_idx,
   input  wire sha256bsh_pkg::word32_type   w,
   output sha256bsh_pkg::word32_type [0:7]  hash
);
   import sha256bsh_pkg::*;

   word32_type hash_ff [8];
   word32_type hash_in [8];
   word32_type work_ff [8];
   word32_type work_in [8];
   word32_type big_s0, big_s1, ch, maj, t1, t2;

   always_comb begin
      big_s1 = {work_ff[4][5:0], work_ff[4][31:6]} ^ {work_ff[4][10:0], work_ff[4][31:11]}
             ^ {work_ff[4][24:0], work_ff[4][31:25]};
      ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + big_s1 + ch + ROUND_K[round_idx] + w;
      big_s0 = {work_ff[0][1:0], work_ff[0][31:2]} ^ {work_ff[0][12:0], work_ff[0][31:13]}
             ^ {work_ff[0][21:0], work_ff[0][31:22]};
      maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t2     = big_s0 + maj;

      work_in = work_ff;
      if (ctrl.init) begin
         work_in = hash_ff;
      end else if (ctrl.step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end

      hash_in = hash_ff;
      if (ctrl.clear) begin
         hash_in = HASH_INIT;
      end else if (ctrl.add) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end

      for (int i = 0; i < 8; i++) begin
         hash[i] = hash_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_INIT;
      end else begin
         hash_ff <= hash_in;
      end
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

[rtl/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream, one byte per req word (a word may carry no byte, and
// last closes the message). Bytes are taken one per cycle while req_stall is low; the
// 64th byte of a block starts the rounds on the shared round unit, followed by a step
// that folds the result into the hash, and req_stall is high meanwhile. On last the
// padding bytes are fed one per cycle, outside the compressions, through the same block
// buffer (one or two more compressions), then four rsp words of 64 bits follow, most
// significant first, through a one-word output register.
// Depends on sha256bsh_pkg, sha256bsh_sched, sha256bsh_core and the defines header.
`default_nettype none

module sha256_byte_stream_hasher #(
   parameter int unsigned LENGTH_BITS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire sha256bsh_pkg::req_word_type req_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output sha256bsh_pkg::rsp_word_type      rsp_word
);
   import sha256bsh_pkg::*;
   `include "sha256_byte_stream_hasher_defines.svh"

   localparam int unsigned CNT_W     = LENGTH_BITS - 3;
   localparam logic [1:0]  LAST_PART = 2'd3;

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT} state_type;
   typedef enum logic [1:0] {PH_MARK, PH_ZERO, PH_LEN} phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [5:0]       pos_ff, pos_in, pos_plus;
   logic [5:0]       round_ff, round_in;
   logic [1:0]       part_ff, part_in;
   logic             closing_ff, closing_in;
   logic             final_ff, final_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             req_take, out_free;
   logic [63:0]      len_bits;
   logic [7:0]       pad_byte;
   sched_ctrl_type   sched_ctrl;
   core_ctrl_type    core_ctrl;
   word32_type       w;
   word32_type [0:7] hash;

   sha256bsh_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w     (w)
   );

   sha256bsh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (core_ctrl),
      .round_idx (round_ff),
      .w         (w),
      .hash      (hash)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign pos_plus  = pos_ff + 6'd1;
   assign len_bits  = 64'({count_ff, 3'b000});

   always_comb begin
      case (phase_ff)
         PH_MARK: pad_byte = PAD_MARK;
         PH_ZERO: pad_byte = 8'h00;
         PH_LEN:  pad_byte = len_bits[{~pos_ff[2:0], 3'b000} +: 8];
         default: pad_byte = 8'h00;
      endcase

      sched_ctrl.load     = (req_take && req_word.has_byte) || (state_ff == S_PAD);
      sched_ctrl.byte_val = (state_ff == S_PAD) ? pad_byte : req_word.data_byte;
      sched_ctrl.step     = (state_ff == S_ROUND);
      sched_ctrl.expand   = (round_ff[5:4] != 2'b00);

      core_ctrl.init  = sched_ctrl.load && (pos_ff == LAST_POS);
      core_ctrl.step  = (state_ff == S_ROUND);
      core_ctrl.add   = (state_ff == S_ADD);
      core_ctrl.clear = (state_ff == S_OUT) && out_free && (part_ff == LAST_PART);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      part_in      = part_ff;
      closing_in   = closing_ff;
      final_in     = final_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_word.has_byte) begin
                  count_in = count_ff + CNT_W'(1);
                  pos_in   = pos_plus;
                  if (pos_ff == LAST_POS) begin
                     state_in   = S_ROUND;
                     round_in   = '0;
                     closing_in = req_word.last;
                  end else if (req_word.last) begin
                     state_in   = S_PAD;
                     closing_in = 1'b1;
                  end
               end else if (req_word.last) begin
                  state_in   = S_PAD;
                  closing_in = 1'b1;
               end
            end
         end
         S_PAD: begin
            pos_in = pos_plus;
            if (phase_ff == PH_LEN) begin
               if (pos_ff == LAST_POS) begin
                  final_in = 1'b1;
               end
            end else begin
               phase_in = (pos_plus == LEN_POS) ? PH_LEN : PH_ZERO;
            end
            if (pos_ff == LAST_POS) begin
               state_in = S_ROUND;
               round_in = '0;
            end
         end
         S_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (!closing_ff) begin
               state_in = S_IDLE;
            end else if (final_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.digest_part = {hash[{part_ff, 1'b0}], hash[{part_ff, 1'b1}]};
               rsp_word_in.part_index  = part_ff;
               rsp_word_in.last_part   = (part_ff == LAST_PART);
               part_in                 = part_ff + 2'd1;
               if (part_ff == LAST_PART) begin
                  state_in   = S_IDLE;
                  phase_in   = PH_MARK;
                  closing_in = 1'b0;
                  final_in   = 1'b0;
                  count_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_MARK;
         pos_ff       <= '0;
         round_ff     <= '0;
         part_ff      <= '0;
         closing_ff   <= 1'b0;
         final_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         part_ff      <= part_in;
         closing_ff   <= closing_in;
         final_ff     <= final_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   `SHA256BSH_ASSERT_NEXT(a_round_end, clock, reset, (state_ff == S_ROUND && round_ff == LAST_ROUND), (state_ff == S_ADD), "round 63 not followed by hash update")
   `SHA256BSH_ASSERT_NOW(a_len_pos, clock, reset, (state_ff == S_PAD && phase_ff == PH_LEN), (pos_ff[5:3] == 3'b111), "length byte outside last eight block bytes")
   `SHA256BSH_ASSERT_NEXT(a_last_part, clock, reset, (state_ff == S_OUT && out_free && part_ff == LAST_PART), (rsp_valid_ff && rsp_word_ff.last_part && state_ff == S_IDLE), "final digest word not issued")
   `SHA256BSH_ASSERT_NOW(a_final_closing, clock, reset, final_ff, closing_ff, "final block flagged outside message close")

endmodule

`default_nettype wire

[bench/sha256_byte_stream_hasher_tb.sv]
// testbench for sha256_byte_stream_hasher: random byte messages with idle bursts on both sides
// a scoreboard class recomputes each digest and checks every rsp word in order
// depends on sha256bsh_pkg and the hasher rtl
module sha256_byte_stream_hasher_tb;
   import sha256bsh_pkg::*;

   localparam int unsigned LEN_BITS = 64;
   localparam bit [63:0] LEN_MASK = 64'hffff_ffff_ffff_ffff >> (64 - LEN_BITS);
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned LONG_HOLD = 600;
   localparam int unsigned PAD_BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   localparam bit [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam bit [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   class digest_scoreboard;
      bit [31:0] hash_state [8];
      bit [31:0] block_buf [16];
      bit [63:0] byte_count;
      rsp_word_type digest_parts_due [$];
      int unsigned mismatch_count;

      function new();
         hash_state = SHA_IV;
         foreach (block_buf[i]) block_buf[i] = '0;
         byte_count = '0;
         mismatch_count = 0;
      endfunction

      function bit [31:0] rotr(bit [31:0] v, int unsigned s);
         return (v >> s) | (v << (32 - s));
      endfunction

      // 64 rounds, message schedule rolls in place through block_buf
      function void compress_block();
         bit [31:0] a, b, c, d, e, f, g, h;
         bit [31:0] w, t1, t2, s15, s2;
         a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
         e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
         for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
               w = block_buf[t];
            end else begin
               s15 = block_buf[(t - 15) & 15];
               s2 = block_buf[(t - 2) & 15];
               w = block_buf[t & 15]
                   + (rotr(s15, 7) ^ rotr(s15, 18) ^ (s15 >> 3))
                   + block_buf[(t - 7) & 15]
                   + (rotr(s2, 17) ^ rotr(s2, 19) ^ (s2 >> 10));
               block_buf[t & 15] = w;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[t] + w;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
         hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
      endfunction

      // bytes pack big-endian into the block, compress when position 63 is filled
      function void absorb_byte(bit [5:0] pos, bit [7:0] val);
         if (pos[1:0] == 2'd0) block_buf[pos[5:2]] = '0;
         block_buf[pos[5:2]] |= {24'd0, val} << {~pos[1:0], 3'b000};
         if (pos == 6'd63) compress_block();
      endfunction

      function void note_request(req_word_type w);
         bit [5:0] pos;
         bit [63:0] bit_len;
         rsp_word_type part;
         if (w.has_byte) begin
            absorb_byte(byte_count[5:0], w.data_byte);
            byte_count++;
         end
         if (!w.last) return;
         pos = byte_count[5:0];
         absorb_byte(pos, 8'h80);
         pos++;
         while (pos != 6'd56) begin
            absorb_byte(pos, 8'h00);
            pos++;
         end
         bit_len = (byte_count << 3) & LEN_MASK;
         for (int k = 0; k < 8; k++) begin
            absorb_byte(pos, bit_len[63 - 8 * k -: 8]);
            pos++;
         end
         for (int k = 0; k < 4; k++) begin
            part.digest_part = {hash_state[2 * k], hash_state[2 * k + 1]};
            part.part_index = 2'(k);
            part.last_part = (k == 3);
            digest_parts_due.push_back(part);
         end
         hash_state = SHA_IV;
         byte_count = '0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (digest_parts_due.size() == 0) begin
            report_mismatch($sformatf("digest part %h with nothing due", got.digest_part));
            return;
         end
         want = digest_parts_due.pop_front();
         if (got.digest_part !== want.digest_part)
            report_mismatch($sformatf("digest_part %h, want %h", got.digest_part,
                                      want.digest_part));
         if (got.part_index !== want.part_index)
            report_mismatch($sformatf("part_index %0d, want %0d", got.part_index,
                                      want.part_index));
         if (got.last_part !== want.last_part)
            report_mismatch($sformatf("last_part %0b, want %0b", got.last_part,
                                      want.last_part));
      endtask

      function int unsigned pending();
         return digest_parts_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;

   digest_scoreboard sb = new();

   bit idle_on;
   int unsigned hold_cycles;
   int unsigned items_sent;
   int unsigned messages_closed;
   int unsigned quiet_cycles;

   sha256_byte_stream_hasher #(.LENGTH_BITS(LEN_BITS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor and watchdog, both sampling the values from before the edge
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid && !req_stall) sb.note_request(req_word);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_word);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, or a long hold when asked for
   initial begin
      int unsigned n;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_cycles != 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic offer(input logic [7:0] val, input logic has, input logic fin);
      req_word_type w;
      w.data_byte = val;
      w.has_byte = has;
      w.last = fin;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      if (has || fin) items_sent++;
      if (fin) messages_closed++;
   endtask

   task automatic send_message(input int unsigned len);
      bit tail_on_byte;
      tail_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         // occasional word with no byte in the middle of a message
         if ($urandom_range(0, 11) == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         offer(8'($urandom_range(0, 255)), 1'b1, tail_on_byte && (i == len - 1));
      end
      if (!tail_on_byte) offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 20);
         5, 6, 7: return PAD_BOUNDARY_LENS[$urandom_range(0, 7)];
         default: return $urandom_range(0, 130);
      endcase
   endfunction

   // stop offering so the last word is not taken again while waiting
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      idle_on = 1'b1;
      hold_cycles = 0;
      items_sent = 0;
      messages_closed = 0;
      quiet_cycles = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(8'h5a, 1'b0, 1'b0);   // ignored word
      offer(8'hff, 1'b0, 1'b1);   // empty message
      offer(8'hff, 1'b1, 1'b1);   // one byte, closed on the byte
      offer(8'h00, 1'b1, 1'b0);
      offer(8'ha5, 1'b0, 1'b0);
      offer(8'h80, 1'b1, 1'b0);
      offer(8'h00, 1'b0, 1'b1);   // closed by a word with no byte
      offer(8'h61, 1'b1, 1'b0);
      offer(8'h62, 1'b1, 1'b0);
      offer(8'h63, 1'b1, 1'b1);
      wait_drained();

      while (items_sent < 200) send_message(pick_length());

      // sender waits for every digest, then the receiver holds off while messages pile up
      wait_drained();
      hold_cycles = LONG_HOLD;
      repeat (4) send_message($urandom_range(0, 8));
      send_message(70);

      while (items_sent < 330) send_message(pick_length());
      idle_on = 1'b0;
      while (items_sent < 400 || messages_closed < 16) send_message(pick_length());
      req_valid <= 1'b0;

      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.pending() != 0) sb.report_mismatch("digest parts still due at end");
      if (sb.mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
